// ===== design/qse_pkg.sv =====
`default_nettype none

package qse_pkg;

  localparam int CAPACITY    = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int STACK_DEPTH = 7;

  // index into the element store, element count, stack pointer
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [SP_W-1:0]       sp_t;

  // element store read address select
  typedef enum logic [2:0] {
    RD_NONE,
    RD_LO,
    RD_I,
    RD_J,
    RD_K
  } rd_sel_e;

  // element store write select (address and data)
  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,
    WR_I_VJ,
    WR_J_VI,
    WR_LO_VJ,
    WR_J_PV
  } wr_sel_e;

  typedef struct packed {
    logic    range_init;
    logic    pop;
    logic    pivot_cap;
    logic    i_inc;
    logic    j_dec;
    logic    vi_cap;
    logic    vj_cap;
    logic    split;
    logic    emit_load;
    logic    finish;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
  } ctl_t;

  typedef struct packed {
    logic n_ge2;
    logic range_ok;
    logic sp_zero;
    logic i_le_hi;
    logic j_gt_lo;
    logic i_lt_j;
    logic cmp_le;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/qse_in_if.sv =====
`default_nettype none

interface qse_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qse_pkg::DATA_WIDTH-1:0] value;
  logic                                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ===== design/qse_out_if.sv =====
`default_nettype none

interface qse_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qse_pkg::DATA_WIDTH-1:0] sorted_value;
  logic                                  final_res;
  logic                                  overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input final_res, input overflow,
                output ready);
endinterface

`default_nettype wire

// ===== design/qse_datapath.sv =====
`default_nettype none

module qse_datapath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire  qse_pkg::ctl_t                   ctl_i,
  output qse_pkg::sts_t                         sts_o,
  input  wire  signed [qse_pkg::DATA_WIDTH-1:0] in_value_i,
  input  wire                                   out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [qse_pkg::DATA_WIDTH-1:0] out_value_o,
  output logic                                  out_final_o,
  output logic                                  out_overflow_o
);

  localparam int IW = qse_pkg::IDX_W;
  localparam int CW = qse_pkg::CNT_W;

  qse_pkg::data_t mem [qse_pkg::CAPACITY];
  qse_pkg::data_t rdata_q;
  qse_pkg::data_t pv_q, vi_q, vj_q;

  qse_pkg::cnt_t  count_q;
  logic           dropped_q;
  qse_pkg::idx_t  lo_q, hi_q, k_q;
  qse_pkg::cnt_t  i_q, j_q;
  qse_pkg::sp_t   sp_q;
  qse_pkg::idx_t  stk_lo_q [qse_pkg::STACK_DEPTH];
  qse_pkg::idx_t  stk_hi_q [qse_pkg::STACK_DEPTH];
  logic           out_valid_q;

  qse_pkg::idx_t  rd_addr, wr_addr;
  qse_pkg::data_t wr_data;
  logic           rd_en, wr_en, room;

  qse_pkg::idx_t  p;
  qse_pkg::cnt_t  p_x, lo_x, hi_x, pr;
  logic           left_small, right_big, left_big;
  logic           push_en;
  qse_pkg::idx_t  push_lo, push_hi, nxt_lo, nxt_hi;
  qse_pkg::sp_t   pop_idx;

  assign room = (count_q < CW'(qse_pkg::CAPACITY));

  // store port selection
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (ctl_i.rd_sel)
      qse_pkg::RD_LO: rd_addr = lo_q;
      qse_pkg::RD_I:  rd_addr = i_q[IW-1:0];
      qse_pkg::RD_J:  rd_addr = j_q[IW-1:0];
      qse_pkg::RD_K:  rd_addr = k_q;
      default:        rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = vj_q;
    case (ctl_i.wr_sel)
      qse_pkg::WR_LOAD: begin
        wr_en   = room;
        wr_addr = count_q[IW-1:0];
        wr_data = in_value_i;
      end
      qse_pkg::WR_I_VJ: begin
        wr_addr = i_q[IW-1:0];
        wr_data = vj_q;
      end
      qse_pkg::WR_J_VI: begin
        wr_addr = j_q[IW-1:0];
        wr_data = vi_q;
      end
      qse_pkg::WR_LO_VJ: begin
        wr_addr = lo_q;
        wr_data = vj_q;
      end
      qse_pkg::WR_J_PV: begin
        wr_addr = j_q[IW-1:0];
        wr_data = pv_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // split: push the larger side, continue on the smaller one
  always_comb begin
    p          = j_q[IW-1:0];
    p_x        = CW'(p);
    lo_x       = CW'(lo_q);
    hi_x       = CW'(hi_q);
    pr         = p_x + CW'(1);
    left_small = ((p_x - lo_x) <= (hi_x - p_x));
    right_big  = (hi_x > pr);
    left_big   = (p_x > (lo_x + CW'(1)));
    nxt_lo     = IW'(1);
    nxt_hi     = '0;
    if (left_small) begin
      push_en = right_big;
      push_lo = pr[IW-1:0];
      push_hi = hi_q;
      if (left_big) begin
        nxt_lo = lo_q;
        nxt_hi = p - IW'(1);
      end
    end else begin
      push_en = left_big;
      push_lo = lo_q;
      push_hi = p - IW'(1);
      if (right_big) begin
        nxt_lo = pr[IW-1:0];
        nxt_hi = hi_q;
      end
    end
  end

  assign pop_idx = sp_q - qse_pkg::SP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      sp_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_sel == qse_pkg::WR_LOAD) begin
        if (room) begin
          count_q <= count_q + CW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (ctl_i.range_init) begin
        sp_q <= '0;
      end
      if (ctl_i.pop) begin
        sp_q <= pop_idx;
      end
      if (ctl_i.split && push_en && (sp_q < qse_pkg::SP_W'(qse_pkg::STACK_DEPTH))) begin
        sp_q <= sp_q + qse_pkg::SP_W'(1);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctl_i.emit_load) begin
        out_valid_q <= 1'b1;
        k_q         <= k_q + IW'(1);
      end
      if (ctl_i.finish) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
        sp_q      <= '0;
        k_q       <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.range_init) begin
      lo_q <= '0;
      hi_q <= IW'(count_q - CW'(1));
    end
    if (ctl_i.pop) begin
      lo_q <= stk_lo_q[pop_idx];
      hi_q <= stk_hi_q[pop_idx];
    end
    if (ctl_i.split) begin
      lo_q <= nxt_lo;
      hi_q <= nxt_hi;
      if (push_en && (sp_q < qse_pkg::SP_W'(qse_pkg::STACK_DEPTH))) begin
        stk_lo_q[sp_q] <= push_lo;
        stk_hi_q[sp_q] <= push_hi;
      end
    end
    if (ctl_i.pivot_cap) begin
      pv_q <= rdata_q;
      i_q  <= CW'(lo_q) + CW'(1);
      j_q  <= CW'(hi_q);
    end
    if (ctl_i.i_inc) begin
      i_q <= i_q + CW'(1);
    end
    if (ctl_i.j_dec) begin
      j_q <= j_q - CW'(1);
    end
    if (ctl_i.vi_cap) begin
      vi_q <= rdata_q;
    end
    if (ctl_i.vj_cap) begin
      vj_q <= rdata_q;
    end
    if (ctl_i.emit_load) begin
      out_value_o    <= rdata_q;
      out_final_o    <= ((CW'(k_q) + CW'(1)) == count_q);
      out_overflow_o <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.n_ge2     = (count_q >= CW'(2));
    sts_o.range_ok  = (lo_q < hi_q);
    sts_o.sp_zero   = (sp_q == '0);
    sts_o.i_le_hi   = (i_q <= CW'(hi_q));
    sts_o.j_gt_lo   = (j_q > CW'(lo_q));
    sts_o.i_lt_j    = (i_q < j_q);
    sts_o.cmp_le    = ($signed(rdata_q) <= $signed(pv_q));
    sts_o.emit_last = ((CW'(k_q) + CW'(1)) == count_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

// ===== design/qse_controller.sv =====
`default_nettype none

module qse_controller (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_last_i,
  output logic               in_ready_o,
  input  wire qse_pkg::sts_t sts_i,
  output qse_pkg::ctl_t      ctl_o
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_START = 14'b00000000000010,
    S_RANGE = 14'b00000000000100,
    S_GETP  = 14'b00000000001000,
    S_SCANI = 14'b00000000010000,
    S_CMPI  = 14'b00000000100000,
    S_SCANJ = 14'b00000001000000,
    S_CMPJ  = 14'b00000010000000,
    S_CHK   = 14'b00000100000000,
    S_SWJ   = 14'b00001000000000,
    S_FIN1  = 14'b00010000000000,
    S_FIN2  = 14'b00100000000000,
    S_EMRD  = 14'b01000000000000,
    S_EMWR  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.rd_sel = qse_pkg::RD_NONE;
    ctl_o.wr_sel = qse_pkg::WR_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.wr_sel = qse_pkg::WR_LOAD;
          if (in_last_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (sts_i.n_ge2) begin
          ctl_o.range_init = 1'b1;
          state_d          = S_RANGE;
        end else begin
          state_d = S_EMRD;
        end
      end
      S_RANGE: begin
        if (sts_i.range_ok) begin
          ctl_o.rd_sel = qse_pkg::RD_LO;
          state_d      = S_GETP;
        end else if (sts_i.sp_zero) begin
          state_d = S_EMRD;
        end else begin
          ctl_o.pop = 1'b1;
        end
      end
      S_GETP: begin
        ctl_o.pivot_cap = 1'b1;
        state_d         = S_SCANI;
      end
      S_SCANI: begin
        if (sts_i.i_le_hi) begin
          ctl_o.rd_sel = qse_pkg::RD_I;
          state_d      = S_CMPI;
        end else begin
          state_d = S_SCANJ;
        end
      end
      S_CMPI: begin
        if (sts_i.cmp_le) begin
          ctl_o.i_inc = 1'b1;
          state_d     = S_SCANI;
        end else begin
          ctl_o.vi_cap = 1'b1;
          state_d      = S_SCANJ;
        end
      end
      S_SCANJ: begin
        if (sts_i.j_gt_lo) begin
          ctl_o.rd_sel = qse_pkg::RD_J;
          state_d      = S_CMPJ;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CMPJ: begin
        if (sts_i.cmp_le) begin
          ctl_o.vj_cap = 1'b1;
          state_d      = S_CHK;
        end else begin
          ctl_o.j_dec = 1'b1;
          state_d     = S_SCANJ;
        end
      end
      S_CHK: begin
        if (sts_i.i_lt_j) begin
          ctl_o.wr_sel = qse_pkg::WR_I_VJ;
          state_d      = S_SWJ;
        end else begin
          state_d = S_FIN1;
        end
      end
      S_SWJ: begin
        ctl_o.wr_sel = qse_pkg::WR_J_VI;
        state_d      = S_SCANI;
      end
      S_FIN1: begin
        // pivot lands at j; skip when it is already there
        if (sts_i.j_gt_lo) begin
          ctl_o.wr_sel = qse_pkg::WR_LO_VJ;
        end
        state_d = S_FIN2;
      end
      S_FIN2: begin
        ctl_o.wr_sel = qse_pkg::WR_J_PV;
        ctl_o.split  = 1'b1;
        state_d      = S_RANGE;
      end
      S_EMRD: begin
        if (sts_i.out_free) begin
          ctl_o.rd_sel = qse_pkg::RD_K;
          state_d      = S_EMWR;
        end
      end
      S_EMWR: begin
        ctl_o.emit_load = 1'b1;
        if (sts_i.emit_last) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_EMRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/quicksort_engine.sv =====
`default_nettype none

// Quicksort engine. Words arrive on item_i one per cycle and are written into a
// 64-entry element store; a word beyond capacity is dropped and raises the
// overflow bit of every result of that set. The word with last set is stored
// (if there is room) and starts the sort: quicksort with the first element of
// each range as pivot and two indices moving toward each other, ranges kept
// on a 7-entry stack with the smaller side handled first. The store is one
// memory with one write and one registered read port, so every element visit
// of a partition scan is a read followed by a compare, and a swap takes two
// more writes. A set that arrives already in order, rising or falling, is the
// worst case for a first-element pivot: each pass peels off one element.
// Then the set streams out on result_o in ascending signed order, each word
// read from the store and then loaded into the output register, the next read
// waiting until the receiver has taken the previous word, final_res set on the
// last one. item_i is not ready from the last word until the final result has
// been loaded into the output register; that register then holds it while the
// next set loads.
module quicksort_engine (
  input wire            clk_i,
  input wire            rst_ni,
  qse_in_if.sink        item_i,
  qse_out_if.source     result_o
);

  qse_pkg::ctl_t ctl;
  qse_pkg::sts_t sts;

  // sequencing: load, partition passes, emit
  qse_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_last_i  (item_i.last),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // element store, indices, range stack and output register
  qse_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .in_value_i     (item_i.value),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .out_value_o    (result_o.sorted_value),
    .out_final_o    (result_o.final_res),
    .out_overflow_o (result_o.overflow)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef logic signed [qse_pkg::DATA_WIDTH-1:0] sval_t;

  localparam sval_t VAL_MIN = {1'b1, {(qse_pkg::DATA_WIDTH-1){1'b0}}};
  localparam sval_t VAL_MAX = {1'b0, {(qse_pkg::DATA_WIDTH-1){1'b1}}};

  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_RISING,
    FILL_FALLING
  } fill_e;

  typedef struct {
    sval_t value;
    logic  final_res;
    logic  overflow;
  } sorted_word_t;

  // Collect each set as it is accepted, sort it when the last word lands and
  // hold the ascending words until the block emits them.
  class sort_scoreboard;
    sval_t        set_words[$];
    logic         set_dropped;
    sorted_word_t sorted_due[$];
    int           errors;

    function new();
      set_dropped = 1'b0;
      errors      = 0;
    endfunction

    function void sort_set();
      sval_t key;
      int    j;
      for (int i = 1; i < set_words.size(); i++) begin
        key = set_words[i];
        j   = i - 1;
        while (j >= 0 && set_words[j] > key) begin
          set_words[j+1] = set_words[j];
          j--;
        end
        set_words[j+1] = key;
      end
    endfunction

    function void note_word(sval_t value, logic last);
      sorted_word_t w;
      if (set_words.size() < qse_pkg::CAPACITY) begin
        set_words.push_back(value);
      end else begin
        set_dropped = 1'b1;
      end
      if (last) begin
        sort_set();
        foreach (set_words[k]) begin
          w.value     = set_words[k];
          w.final_res = (k == set_words.size() - 1);
          w.overflow  = set_dropped;
          sorted_due.push_back(w);
        end
        set_words.delete();
        set_dropped = 1'b0;
      end
    endfunction

    function void check_result(sval_t value, logic final_res, logic overflow);
      sorted_word_t w;
      if (sorted_due.size() == 0) begin
        $error("unexpected result word: sorted_value %0d", value);
        errors++;
        return;
      end
      w = sorted_due.pop_front();
      if (value !== w.value) begin
        $error("sorted_value: expected %0d, got %0d", w.value, value);
        errors++;
      end
      if (final_res !== w.final_res) begin
        $error("final_res: expected %0b, got %0b", w.final_res, final_res);
        errors++;
      end
      if (overflow !== w.overflow) begin
        $error("overflow: expected %0b, got %0b", w.overflow, overflow);
        errors++;
      end
    endfunction

    function int outstanding();
      return sorted_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  qse_in_if  item_if ();
  qse_out_if result_if ();

  sort_scoreboard sb;

  // idle chance per cycle, in percent, for each side
  int send_idle_pct;
  int recv_idle_pct;
  // cycles the receiver must hold off, picked up by the receiver process
  int hold_req;
  int items_sent;

  quicksort_engine u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Receiver: drive ready at the falling edge. A hold-off request drops ready
  // for a counted stretch of cycles; otherwise stall at random.
  initial begin
    int hold_left;
    hold_left       = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: sample the result channel at the rising edge and check each
  // accepted word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      sb.check_result(result_if.sorted_value, result_if.final_res, result_if.overflow);
    end
  end

  // Offer one word. Idle first at random with valid low, then hold valid and
  // the payload until the block takes the word. Valid stays high into the
  // next word when no idle cycle falls in between.
  task automatic send_word(input sval_t value, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.value <= value;
    item_if.last  <= last;
    @(posedge clk_i);
    while (item_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_word(value, last);
    items_sent++;
  endtask

  // Send a set of n words, last mark on the final one. Rising and falling
  // fills hit the first-pivot worst case; narrow fills give many duplicates.
  task automatic send_set(input int n, input fill_e fill);
    sval_t v;
    int    pitch;
    pitch = $urandom_range(1, 1000000);
    for (int k = 0; k < n; k++) begin
      case (fill)
        FILL_NARROW:  v = sval_t'($urandom_range(0, 6)) - 3;
        FILL_RISING:  v = sval_t'((k - n / 2) * pitch);
        FILL_FALLING: v = sval_t'((n / 2 - k) * pitch);
        default:      v = sval_t'($urandom());
      endcase
      send_word(v, k == n - 1);
    end
  endtask

  // Random sets up to a running word count: mostly short, now and then one
  // that fills the store or spills past it.
  task automatic send_random_until(input int target);
    int n;
    while (items_sent < target) begin
      if ($urandom_range(19) == 0) begin
        n = $urandom_range(qse_pkg::CAPACITY, qse_pkg::CAPACITY + 4);
      end else begin
        n = $urandom_range(1, 12);
      end
      send_set(n, fill_e'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 6;
    recv_idle_pct = 48;
    hold_req      = 0;
    items_sent    = 0;
    item_if.valid = 1'b0;
    item_if.value = '0;
    item_if.last  = 1'b0;

    // Hold reset low, then release it away from the rising edge.
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Single-word set: sorts trivially and is its own final word.
    send_word(VAL_MIN, 1'b1);
    // Both extremes, out of order.
    send_word(VAL_MAX, 1'b0);
    send_word(VAL_MIN, 1'b1);
    // Duplicates around zero.
    send_word(sval_t'(0), 1'b0);
    send_word(sval_t'(-1), 1'b0);
    send_word(sval_t'(1), 1'b0);
    send_word(sval_t'(-1), 1'b0);
    send_word(sval_t'(0), 1'b1);
    // Strictly falling, then strictly rising, across the sign boundary.
    send_word(VAL_MAX, 1'b0);
    send_word(sval_t'(7), 1'b0);
    send_word(sval_t'(-7), 1'b0);
    send_word(VAL_MIN, 1'b1);
    send_word(VAL_MIN, 1'b0);
    send_word(sval_t'(-1), 1'b0);
    send_word(sval_t'(0), 1'b0);
    send_word(VAL_MAX, 1'b1);
    // All equal.
    send_word(sval_t'(5), 1'b0);
    send_word(sval_t'(5), 1'b0);
    send_word(sval_t'(5), 1'b1);
    // Alternating bit patterns.
    send_word(sval_t'(32'hAAAA_AAAA), 1'b0);
    send_word(sval_t'(32'h5555_5555), 1'b1);

    // Store exactly full; full with the marked word itself dropped; a spill
    // of several words before the mark.
    send_set(qse_pkg::CAPACITY, FILL_RANDOM);
    send_set(qse_pkg::CAPACITY + 1, FILL_RISING);
    send_set(qse_pkg::CAPACITY + 3, FILL_NARROW);

    send_random_until(260);

    // Swap the idle pattern: sender sparse, receiver eager.
    send_idle_pct = 48;
    recv_idle_pct = 6;
    send_random_until(360);

    // No idling. Hold the receiver off first so the block fills up and
    // stalls its input while words keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 3000;
    send_random_until(445);

    @(negedge clk_i);
    item_if.valid <= 1'b0;

    // Drain, then give the block time to show any stray word.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
